/* rtl/core/pcb_pkg.sv */
// Shared types and constants for the particle cell binning block.
`default_nettype none
package pcb_pkg;

   localparam int OP_W      = 2;
   localparam int ID_W      = 6;
   localparam int POS_W     = 32;
   localparam int QIDX_W    = 4;
   localparam int QSLOT_W   = 6;
   localparam int DIM_W     = 5;
   localparam int OUT_CNT_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int REQ_DAT_W = 88;
   localparam int RSP_DAT_W = 24;

   // grid store size, tied to the 4-bit row/column and 6-bit slot fields
   localparam int MAX_ROWS      = 16;
   localparam int MAX_COLS      = 16;
   localparam int MAX_PARTICLES = 64;

   // quotient of one axis is below the grid size, which fits DIM_W bits
   localparam int QUOT_W = DIM_W;
   localparam int NUM_W  = POS_W + DIM_W;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_MUL,
      S_DSTART,
      S_DIV,
      S_LOOK,
      S_CNT,
      S_LIST,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

/* rtl/core/pcb_div.sv */
// Restoring divider producing a short quotient, one bit per cycle.
`default_nettype none
module pcb_div
   import pcb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_W-1:0]    num,
   input  wire logic [POS_W-1:0]    den,
   output logic                     done,
   output logic [QUOT_W-1:0]        quot
);

   localparam int STEP_W = $clog2(QUOT_W);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W:0]    dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W:0]    trial;

   assign trial = {1'b0, rem_ff} - dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         // divisor aligned to the top quotient bit
         dsh_in  = (NUM_W+1)'(den) << (QUOT_W - 1);
         quot_in = '0;
         step_in = STEP_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[NUM_W]) begin
            rem_in = trial[NUM_W-1:0];
         end
         quot_in = {quot_ff[QUOT_W-2:0], ~trial[NUM_W]};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

/* rtl/core/particle_cell_binning.sv */
// Top level of the particle cell binning block.
//
// Requests arrive on the req_ stream: tuser carries the opcode (clear, insert,
// read), tdata the particle id, position and query fields. Every request
// returns exactly one response on the rsp_ stream.
// Registers (grid bounds and size) are written on the csr_ channel; the user
// must write them only while idle, as the block itself does not enforce it.
// One request is worked on at a time. A clear or unused opcode goes straight
// to the response state; a read reads the count memory then the list memory,
// each through a registered read port. An insert makes two passes through a
// shared restoring divider that yields one quotient bit per cycle, first for
// the column then for the row, plus setup and the count read-modify-write.
// The response sits in an output register; the next request is taken while
// it waits, and the block stalls only when a second response is ready before
// the first one has been taken.
// Reset clears the per-cell valid bits (empty counts) and loads the default
// grid of [0,1) x [0,1) with 16 x 16 cells; no clearing pass is needed.
`default_nettype none
module particle_cell_binning
   import pcb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // particle_id, pos_x, pos_y, query_row, query_col, query_slot, zero fill
   input  wire logic [REQ_DAT_W-1:0]  req_tdata,
   // opcode
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // cell_row, cell_col, cell_count, entry_id, slot_valid, status, zero fill
   output logic [RSP_DAT_W-1:0]       rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_data
);

   localparam int NUM_CELLS  = MAX_ROWS * MAX_COLS;
   localparam longint LIST_DEPTH = longint'(NUM_CELLS) * longint'(MAX_PARTICLES);
   localparam int CELL_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int SLOT_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
   localparam int LADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   // configuration
   logic signed [POS_W-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [DIM_W-1:0]        rows_ff, cols_ff;
   logic [DIM_W-1:0]        rows_eff, cols_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         x_max_ff <= 32'sd65536;
         y_min_ff <= '0;
         y_max_ff <= 32'sd65536;
         rows_ff  <= 5'd16;
         cols_ff  <= 5'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_X_MIN: x_min_ff <= csr_data;
            CSR_X_MAX: x_max_ff <= csr_data;
            CSR_Y_MIN: y_min_ff <= csr_data;
            CSR_Y_MAX: y_max_ff <= csr_data;
            CSR_ROWS:  rows_ff  <= csr_data[DIM_W-1:0];
            CSR_COLS:  cols_ff  <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign rows_eff = (int'(rows_ff) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (int'(cols_ff) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_ff;

   // request fields
   logic [OP_W-1:0]         op_ff;
   logic [ID_W-1:0]         pid_ff;
   logic signed [POS_W-1:0] px_ff, py_ff;
   logic [QIDX_W-1:0]       qrow_ff, qcol_ff;
   logic [QSLOT_W-1:0]      qslot_ff;

   state_type state_ff, state_in;
   logic      accept;
   logic      rsp_load;
   logic      axis_ff;
   logic      div_start, div_done;
   logic [QUOT_W-1:0] div_quot;

   // axis setup
   logic [POS_W-1:0] diffx_ff, diffy_ff, rangex_ff, rangey_ff;
   logic             inx_ff, iny_ff;
   logic [NUM_W-1:0] num_ff;
   logic [POS_W-1:0] den_ff;
   logic [QUOT_W-1:0] colq_ff, rowq_ff;

   // memories
   logic [CNT_W-1:0]  count_mem [NUM_CELLS];
   logic [ID_W-1:0]   list_mem  [LIST_DEPTH];
   logic [NUM_CELLS-1:0] cell_valid_ff;
   logic [CELL_W-1:0] cell_ff;
   logic [CNT_W-1:0]  count_rd_ff;
   logic              count_ok_ff;
   logic [ID_W-1:0]   list_rd_ff;
   logic [CNT_W-1:0]  cnt_cur;
   logic              cnt_full;
   logic              slot_hit;
   logic              count_we, list_we;
   logic [LADDR_W-1:0] list_addr;

   // result register fields
   logic [QIDX_W-1:0]    res_row_ff, res_col_ff;
   logic [OUT_CNT_W-1:0] res_cnt_ff;
   logic [ID_W-1:0]      res_id_ff;
   logic                 res_valid_ff, res_stat_ff;
   logic [RSP_DAT_W-1:0] rsp_data_ff;
   logic                 rsp_tvalid_ff;

   assign cnt_cur  = count_ok_ff ? count_rd_ff : '0;
   assign cnt_full = (int'(cnt_cur) >= MAX_PARTICLES);
   assign slot_hit = (CNT_W'(qslot_ff) < cnt_cur) && (int'(qslot_ff) < MAX_PARTICLES);

   // insert writes at slot cnt, read fetches at the queried slot
   assign list_addr = LADDR_W'(cell_ff) * LADDR_W'(MAX_PARTICLES)
                    + ((op_ff == OP_INSERT) ? LADDR_W'(cnt_cur) : LADDR_W'(qslot_ff));

   pcb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_INSERT) begin
                  state_in = S_PREP;
               end else if (req_tuser == OP_READ) begin
                  state_in = S_LOOK;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_PREP:   state_in = S_MUL;
         S_MUL:    state_in = S_DSTART;
         S_DSTART: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = axis_ff ? S_LOOK : S_MUL;
            end
         end
         S_LOOK:   state_in = S_CNT;
         S_CNT:    state_in = (op_ff == OP_READ) ? S_LIST : S_RESP;
         S_LIST:   state_in = S_RESP;
         S_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      count_we   = 1'b0;
      list_we    = 1'b0;
      case (state_ff)
         S_IDLE:   req_tready = 1'b1;
         S_DSTART: div_start  = 1'b1;
         S_CNT: begin
            count_we = (op_ff == OP_INSERT) && !cnt_full;
            list_we  = (op_ff == OP_INSERT) && !cnt_full;
         end
         S_RESP:   rsp_load = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_ff        <= req_tuser;
               pid_ff       <= req_tdata[5:0];
               px_ff        <= req_tdata[37:6];
               py_ff        <= req_tdata[69:38];
               qrow_ff      <= req_tdata[73:70];
               qcol_ff      <= req_tdata[77:74];
               qslot_ff     <= req_tdata[83:78];
               axis_ff      <= 1'b0;
               res_row_ff   <= '0;
               res_col_ff   <= '0;
               res_cnt_ff   <= '0;
               res_id_ff    <= '0;
               res_valid_ff <= 1'b0;
               res_stat_ff  <= 1'b0;
               if (req_tuser == OP_READ) begin
                  if ((DIM_W'(req_tdata[73:70]) < rows_eff)
                      && (DIM_W'(req_tdata[77:74]) < cols_eff)) begin
                     cell_ff    <= CELL_W'(int'(req_tdata[73:70]) * MAX_COLS
                                           + int'(req_tdata[77:74]));
                     res_row_ff <= req_tdata[73:70];
                     res_col_ff <= req_tdata[77:74];
                  end else begin
                     cell_ff <= '0;
                  end
               end
            end
         end
         S_PREP: begin
            inx_ff    <= (px_ff >= x_min_ff) && (px_ff < x_max_ff);
            iny_ff    <= (py_ff >= y_min_ff) && (py_ff < y_max_ff);
            diffx_ff  <= px_ff - x_min_ff;
            diffy_ff  <= py_ff - y_min_ff;
            rangex_ff <= x_max_ff - x_min_ff;
            rangey_ff <= y_max_ff - y_min_ff;
         end
         S_MUL: begin
            // out-of-range coordinate divides zero and lands on index 0
            if (!axis_ff) begin
               num_ff <= inx_ff ? NUM_W'(diffx_ff) * NUM_W'(cols_eff) : '0;
               den_ff <= inx_ff ? rangex_ff : POS_W'(1);
            end else begin
               num_ff <= iny_ff ? NUM_W'(diffy_ff) * NUM_W'(rows_eff) : '0;
               den_ff <= iny_ff ? rangey_ff : POS_W'(1);
            end
         end
         S_DIV: begin
            if (div_done) begin
               axis_ff <= 1'b1;
               if (!axis_ff) begin
                  colq_ff <= div_quot;
               end else begin
                  rowq_ff <= div_quot;
                  cell_ff <= CELL_W'(int'(div_quot) * MAX_COLS + int'(colq_ff));
               end
            end
         end
         S_CNT: begin
            res_cnt_ff <= OUT_CNT_W'(cnt_cur);
            if (op_ff == OP_INSERT) begin
               res_row_ff <= rowq_ff[QIDX_W-1:0];
               res_col_ff <= colq_ff[QIDX_W-1:0];
               if (cnt_full) begin
                  res_stat_ff <= 1'b1;
               end else begin
                  res_cnt_ff <= OUT_CNT_W'(cnt_cur + 1'b1);
               end
            end else begin
               res_valid_ff <= slot_hit;
            end
         end
         S_LIST: begin
            res_id_ff <= res_valid_ff ? list_rd_ff : '0;
         end
         default: ;
      endcase
   end

   // count store, valid bits stand for the cleared state
   always_ff @(posedge clock) begin
      count_rd_ff <= count_mem[cell_ff];
      count_ok_ff <= cell_valid_ff[cell_ff];
      if (count_we) begin
         count_mem[cell_ff] <= CNT_W'(cnt_cur + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= '0;
      end else if (accept && req_tuser == OP_CLEAR) begin
         cell_valid_ff <= '0;
      end else if (count_we) begin
         cell_valid_ff[cell_ff] <= 1'b1;
      end
   end

   // particle lists
   always_ff @(posedge clock) begin
      list_rd_ff <= list_mem[list_addr];
      if (list_we) begin
         list_mem[list_addr] <= pid_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, res_stat_ff, res_valid_ff, res_id_ff, res_cnt_ff,
                         res_col_ff, res_row_ff};
      end
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
